[rtl/bfmau_pkg.sv]
package bfmau_pkg;

  // Geometry of the address word
  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 32;
  localparam int LIMIT_W    = 13;
  localparam int FIELD_W    = 5;
  localparam int SIZE_LSB   = 27;
  localparam int SHIFT_LSB  = 22;
  localparam int LOW_W      = 22;
  localparam int LIMIT_REGS = 4;
  localparam int CFG_IDX_W  = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_READ_BASE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROTECT_BASE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END          = 4'd8;

  // Access modes
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_PROTECT = 2'd2
  } status_t;

  // Field control carried along with an access
  typedef struct packed {
    logic               write;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] shift;
  } field_ctl_t;

  // Address advanced by one field, or by one word for size zero
  function automatic logic [ADDR_W-1:0] field_advance(input logic [ADDR_W-1:0] addr);
    logic [FIELD_W-1:0] size;
    logic [FIELD_W:0]   shift_sum;
    logic [FIELD_W+1:0] reach;
    logic [LOW_W-1:0]   low;
    size      = addr[SIZE_LSB +: FIELD_W];
    shift_sum = {1'b0, addr[SHIFT_LSB +: FIELD_W]} + {1'b0, size};
    reach     = {1'b0, shift_sum} + {2'b00, size};
    low       = addr[LOW_W-1:0];
    if (size == '0) begin
      field_advance = addr + 32'd1;
    end else if (reach > 7'd32) begin
      field_advance = {size, shift_sum[FIELD_W-1:0], low + 22'd1};
    end else begin
      field_advance = {size, shift_sum[FIELD_W-1:0], low};
    end
  endfunction

endpackage

[rtl/bfmau_limits.sv]
module bfmau_limits (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bfmau_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfmau_pkg::LIMIT_W-1:0]        cfg_data,
  input  logic [bfmau_pkg::FIELD_W-1:0]        page,
  output logic [bfmau_pkg::LIMIT_W-1:0]        read_limit,
  output logic [bfmau_pkg::LIMIT_W-1:0]        protect_limit
);

  logic [bfmau_pkg::LIMIT_W-1:0] read_lim [bfmau_pkg::LIMIT_REGS];
  logic [bfmau_pkg::LIMIT_W-1:0] prot_lim [bfmau_pkg::LIMIT_REGS];

  // Capture register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bfmau_pkg::LIMIT_REGS; i++) begin
        read_lim[i] <= '0;
        prot_lim[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index < bfmau_pkg::REG_PROTECT_BASE) begin
        read_lim[2'(cfg_index - bfmau_pkg::REG_READ_BASE)] <= cfg_data;
      end else if (cfg_index < bfmau_pkg::REG_END) begin
        prot_lim[2'(cfg_index - bfmau_pkg::REG_PROTECT_BASE)] <= cfg_data;
      end
    end
  end

  // Look up limits; pages without registers get zero limits
  always_comb begin
    if (page < bfmau_pkg::FIELD_W'(bfmau_pkg::LIMIT_REGS)) begin
      read_limit    = read_lim[page[1:0]];
      protect_limit = prot_lim[page[1:0]];
    end else begin
      read_limit    = '0;
      protect_limit = '0;
    end
  end

endmodule

[rtl/bfmau_store.sv]
module bfmau_store #(
  parameter int IDX_W = 14
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [IDX_W-1:0]               rd_idx,
  output logic [bfmau_pkg::DATA_W-1:0]   rd_data,
  input  logic                           wr_en,
  input  logic [IDX_W-1:0]               wr_idx,
  input  logic [bfmau_pkg::DATA_W-1:0]   wr_data
);

  logic [bfmau_pkg::DATA_W-1:0] mem [2**IDX_W];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Registered read port; holds its word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

[rtl/bfmau_field.sv]
module bfmau_field (
  input  logic [bfmau_pkg::FIELD_W-1:0]      size,
  input  logic [bfmau_pkg::FIELD_W-1:0]      shift,
  input  logic [bfmau_pkg::DATA_W-1:0]       cur,
  input  logic [bfmau_pkg::DATA_W-1:0]       wdata,
  output logic [bfmau_pkg::DATA_W-1:0]       merged,
  output logic [bfmau_pkg::DATA_W-1:0]       extracted
);

  logic [bfmau_pkg::DATA_W-1:0] mask;
  logic [bfmau_pkg::DATA_W-1:0] mask_at;

  // Build the field mask; bits shifted above the word are dropped
  assign mask    = bfmau_pkg::DATA_W'((33'd1 << size) - 33'd1);
  assign mask_at = mask << shift;

  // Merge a field into the word, or take the whole word for size zero
  always_comb begin
    if (size == '0) begin
      merged    = wdata;
      extracted = cur;
    end else begin
      merged    = ((wdata & mask) << shift) | (cur & ~mask_at);
      extracted = (cur >> shift) & mask;
    end
  end

endmodule

[rtl/bitfield_memory_access_unit_top.sv]
// A result passes through the access stage and the output register before it is offered.
// Throughput: one item per cycle while the output is not stalled; the word store has
// one read and one write port, and a field write merges in the cycle after the read.
// A write to the word the next item reads is forwarded around the store.
// Reset clears the limit registers and the pipeline; the word store is not cleared.
module bitfield_memory_access_unit_top #(
  parameter int PAGES      = 4,
  parameter int PAGE_WORDS = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [bfmau_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfmau_pkg::LIMIT_W-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  mode,
  input  logic [31:0]                           address,
  input  logic signed [31:0]                    write_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [31:0]                           read_data,
  output logic [1:0]                            status,
  output logic [31:0]                           next_address
);

  localparam int PB         = $clog2(PAGES);
  localparam int WB         = $clog2(PAGE_WORDS);
  localparam int IDX_W      = PB + WB;
  localparam int PAGE_SHIFT = bfmau_pkg::LOW_W - PB;
  localparam int CMP_W      = 22;
  localparam logic [bfmau_pkg::FIELD_W-1:0] PAGE_MASK = bfmau_pkg::FIELD_W'((1 << PB) - 1);

  // Decode of the incoming address
  logic [bfmau_pkg::FIELD_W-1:0] page;
  logic [WB-1:0]                 word;
  logic [IDX_W-1:0]              idx;
  logic [bfmau_pkg::LIMIT_W-1:0] rlim;
  logic [bfmau_pkg::LIMIT_W-1:0] plim;
  bfmau_pkg::status_t            status_in;
  logic                          accept;
  logic                          advance;
  logic                          out_free;

  // Access stage
  logic                          s1_valid;
  bfmau_pkg::field_ctl_t         s1_ctl;
  logic [31:0]                   s1_data;
  bfmau_pkg::status_t            s1_status;
  logic                          s1_wen;
  logic [IDX_W-1:0]              s1_idx;
  logic [31:0]                   s1_next;
  logic                          fwd_hit;
  logic [31:0]                   fwd_data;
  logic [31:0]                   mem_rdata;
  logic [31:0]                   cur;
  logic [31:0]                   merged;
  logic [31:0]                   extracted;

  assign page = bfmau_pkg::FIELD_W'(address[bfmau_pkg::LOW_W-1:0] >> PAGE_SHIFT) & PAGE_MASK;
  assign word = address[WB-1:0];
  assign idx  = IDX_W'((32'(page) << WB) | 32'(word));

  bfmau_limits u_limits (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .page          (page),
    .read_limit    (rlim),
    .protect_limit (plim)
  );

  // Check the page and word against the limits
  always_comb begin
    if ((6'(page) >= 6'(PAGES)) || (CMP_W'(word) >= CMP_W'(PAGE_WORDS)) ||
        (CMP_W'(word) >= CMP_W'(rlim))) begin
      status_in = bfmau_pkg::ST_INVALID;
    end else if ((mode == bfmau_pkg::MODE_WRITE) && (CMP_W'(word) < CMP_W'(plim))) begin
      status_in = bfmau_pkg::ST_PROTECT;
    end else begin
      status_in = bfmau_pkg::ST_OK;
    end
  end

  // Handshake: the access stage drains into the output register when it is free
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  bfmau_store #(
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_idx  (idx),
    .rd_data (mem_rdata),
    .wr_en   (advance && s1_wen),
    .wr_idx  (s1_idx),
    .wr_data (merged)
  );

  // Take the forwarded word when the previous item wrote this entry
  assign cur = fwd_hit ? fwd_data : mem_rdata;

  bfmau_field u_field (
    .size      (s1_ctl.size),
    .shift     (s1_ctl.shift),
    .cur       (cur),
    .wdata     (s1_data),
    .merged    (merged),
    .extracted (extracted)
  );

  // Load the access stage on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      fwd_hit  <= advance && s1_wen && (s1_idx == idx);
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl.write <= mode;
      s1_ctl.size  <= address[bfmau_pkg::SIZE_LSB +: bfmau_pkg::FIELD_W];
      s1_ctl.shift <= address[bfmau_pkg::SHIFT_LSB +: bfmau_pkg::FIELD_W];
      s1_data      <= write_data;
      s1_status    <= status_in;
      s1_wen       <= (mode == bfmau_pkg::MODE_WRITE) && (status_in == bfmau_pkg::ST_OK);
      s1_idx       <= idx;
      s1_next      <= bfmau_pkg::field_advance(address);
      fwd_data     <= merged;
    end
  end

  // Output register: load on advance, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status       <= s1_status;
      next_address <= s1_next;
      if ((s1_status == bfmau_pkg::ST_OK) && (s1_ctl.write == bfmau_pkg::MODE_READ)) begin
        read_data <= extracted;
      end else begin
        read_data <= '0;
      end
    end
  end

endmodule

[rtl/bfmau_checker.sv]
module bfmau_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] read_data,
  input logic [1:0]  status,
  input logic [31:0] next_address
);

  // No result is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // Status carries only the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == bfmau_pkg::ST_OK || status == bfmau_pkg::ST_INVALID ||
                   status == bfmau_pkg::ST_PROTECT))
    else $error("undefined status code");

  // A refused access returns no data
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != bfmau_pkg::ST_OK) |-> (read_data == '0))
    else $error("data returned on refused access");

  // The input is held back only by a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status) &&
                               $stable(next_address))
    else $error("stalled result changed");

endmodule

bind bitfield_memory_access_unit_top bfmau_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .read_data    (read_data),
  .status       (status),
  .next_address (next_address)
);
